[rtl/mcl_pkg.sv]
// ----------------------------------------------------------------------------
// mcl_pkg: shared types and constants of the modexp cascade lock check unit
// Holds register indexes, reset values, stage codes and small structs.
// ----------------------------------------------------------------------------
package mcl_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned SMALL_W = 32;
	localparam int unsigned SEAL_W  = 34;
	localparam int unsigned OUT_W   = 33;
	localparam int unsigned IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_PRIME  = 3'd0;
	localparam logic [IDX_W-1:0] REG_BASE   = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROD    = 3'd2;
	localparam logic [IDX_W-1:0] REG_CONE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_SIGNAL = 3'd4;
	localparam logic [IDX_W-1:0] REG_ALPHA  = 3'd5;
	localparam logic [IDX_W-1:0] REG_BETA   = 3'd6;

	localparam logic [WORD_W-1:0]  RST_PRIME  = 64'd953467954114363;
	localparam logic [WORD_W-1:0]  RST_BASE   = 64'd381387181645745;
	localparam logic [WORD_W-1:0]  RST_ROD    = 64'd88776655;
	localparam logic [WORD_W-1:0]  RST_CONE   = 64'd44332211;
	localparam logic [WORD_W-1:0]  RST_SIGNAL = 64'd1000;
	localparam logic [SMALL_W-1:0] RST_ALPHA  = 32'd24;
	localparam logic [SMALL_W-1:0] RST_BETA   = 32'd100;

	localparam logic [1:0] FAIL_NONE     = 2'd0;
	localparam logic [1:0] FAIL_MANIFOLD = 2'd1;
	localparam logic [1:0] FAIL_RING     = 2'd2;

	// command to the modexp engine
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] base;
		logic [WORD_W-1:0] expo;
		logic [WORD_W-1:0] modulus;
	} pow_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] value;
	} pow_rsp_t;

endpackage

[rtl/mcl_if.sv]
// ----------------------------------------------------------------------------
// mcl_req_if / mcl_res_if: valid-ready channels of the unit
// Request carries the lock fields, result carries the sealed state.
// ----------------------------------------------------------------------------
interface mcl_req_if;
	logic        valid;
	logic        ready;
	logic        lock_enable;
	logic [63:0] npn_value;
	logic [63:0] pnp_value;
	modport source (output valid, lock_enable, npn_value, pnp_value, input ready);
	modport sink (input valid, lock_enable, npn_value, pnp_value, output ready);
endinterface

interface mcl_res_if;
	logic        valid;
	logic        ready;
	logic        converged;
	logic [1:0]  fail_stage;
	logic [32:0] manifold_out;
	logic [32:0] ring_out;
	logic [32:0] barn_out;
	logic [63:0] monopole_out;
	modport source (output valid, converged, fail_stage, manifold_out, ring_out,
		barn_out, monopole_out, input ready);
	modport sink (input valid, converged, fail_stage, manifold_out, ring_out,
		barn_out, monopole_out, output ready);
endinterface

[rtl/mcl_mulmod.sv]
// ----------------------------------------------------------------------------
// mcl_mulmod: (a * b) mod m, one multiplier bit per cycle
// Shift-add with two conditional subtracts each cycle; m of zero wraps.
// ----------------------------------------------------------------------------
module mcl_mulmod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [63:0] m,
	output logic        done,
	output logic [63:0] result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RED  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0]  state_q;
	logic [5:0]  bit_q;
	logic        red_b_q;
	logic [63:0] a_q, b_q, m_q, acc_q, rem_q;
	logic [64:0] dbl, sum;
	logic [63:0] acc_d;
	logic        rem_done;
	logic [63:0] rem_next;

	// remainder of a_q or b_q by m: restoring division, one bit a cycle
	logic [64:0] rem_sh;
	assign rem_sh   = {rem_q, red_b_q ? b_q[bit_q] : a_q[bit_q]};
	assign rem_next = (rem_sh >= {1'b0, m_q}) ? 64'(rem_sh - {1'b0, m_q}) : rem_sh[63:0];
	assign rem_done = (bit_q == 6'd0);

	// with m of zero the subtracts take away nothing and the low 64 bits wrap
	always_comb begin
		dbl = {acc_q, 1'b0};
		if (dbl >= {1'b0, m_q})
			dbl = dbl - {1'b0, m_q};
		sum = dbl;
		if (b_q[bit_q]) begin
			sum = dbl + {1'b0, a_q};
			if (sum >= {1'b0, m_q})
				sum = sum - {1'b0, m_q};
		end
		acc_d = sum[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						m_q     <= m;
						rem_q   <= 64'd0;
						acc_q   <= 64'd0;
						bit_q   <= 6'd63;
						red_b_q <= 1'b0;
						state_q <= (m == 64'd0) ? ST_RUN : ST_RED;
					end
				end
				ST_RED: begin
					rem_q <= rem_next;
					bit_q <= bit_q - 6'd1;
					if (rem_done) begin
						rem_q <= 64'd0;
						if (red_b_q) begin
							b_q     <= rem_next;
							acc_q   <= 64'd0;
							state_q <= ST_RUN;
						end else begin
							a_q     <= rem_next;
							red_b_q <= 1'b1;
						end
					end
				end
				ST_RUN: begin
					acc_q <= acc_d;
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd0) begin
						result  <= acc_d;
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/mcl_powmod.sv]
// ----------------------------------------------------------------------------
// mcl_powmod: square-and-multiply modexp over the shared mulmod unit
// Runs one multiply (for a set bit) and one square per exponent bit, but no square after the top bit.
// ----------------------------------------------------------------------------
module mcl_powmod (
	input  logic              clk,
	input  logic              arst_n,
	input  mcl_pkg::pow_req_t req,
	output mcl_pkg::pow_rsp_t rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_MWT  = 3'd2;
	localparam logic [2:0] ST_SQR  = 3'd3;
	localparam logic [2:0] ST_SWT  = 3'd4;

	logic [2:0]  state_q;
	logic [63:0] base_q, e_q, m_q, res_q;
	logic        mm_start;
	logic [63:0] mm_a;
	logic        mm_done;
	logic [63:0] mm_res;

	mcl_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .a(mm_a), .b(base_q),
		.m(m_q), .done(mm_done), .result(mm_res)
	);

	always_comb begin
		mm_start = 1'b0;
		mm_a     = base_q;
		unique case (state_q)
			ST_MUL: begin
				mm_start = e_q[0];
				mm_a     = res_q;
			end
			ST_SQR:  mm_start = 1'b1;
			default: mm_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rsp.done <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						base_q <= req.base;
						e_q    <= req.expo;
						m_q    <= req.modulus;
						res_q  <= 64'd1;
						if (req.expo == 64'd0) begin
							rsp.value <= 64'd1;
							rsp.done  <= 1'b1;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: state_q <= e_q[0] ? ST_MWT : ST_SQR;
				ST_MWT: begin
					if (mm_done) begin
						res_q <= mm_res;
						// last set bit: skip the final square
						if (e_q[63:1] == 63'd0) begin
							rsp.value <= mm_res;
							rsp.done  <= 1'b1;
							state_q   <= ST_IDLE;
						end else begin
							state_q <= ST_SQR;
						end
					end
				end
				ST_SQR: state_q <= ST_SWT;
				ST_SWT: begin
					// squaring done: drop one exponent bit
					if (mm_done) begin
						base_q  <= mm_res;
						e_q     <= e_q >> 1;
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/modexp_cascade_lock_check_unit.sv]
// ----------------------------------------------------------------------------
// modexp_cascade_lock_check_unit: modexp cascade with lock check
// Sequences the cascade of modular exponentiations over one modexp engine.
// ----------------------------------------------------------------------------
// channel | dir | handshake   | payload
// req     | in  | valid/ready | lock_enable, npn_value, pnp_value
// res     | out | valid/ready | converged, fail_stage, sealed values
// cfg     | in  | cfg_we      | cfg_index, cfg_data
// Up to thirteen modexps run in turn, each one square and at most one multiply per
// exponent bit in the shared mulmod unit. Eight modexps take 64-bit exponents and
// four take exponents below 2^33.
// Base reduction modulo the prime runs through the same engine as x^1.
// req.ready is low from acceptance until the result item is taken.
// Reset restores the register defaults and clears the sealed state.
// ----------------------------------------------------------------------------
module modexp_cascade_lock_check_unit #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	mcl_req_if.sink      req,
	mcl_res_if.source    res
);

	localparam logic [63:0] DW_MASK = (DATA_WIDTH >= 64) ? '1 :
		((64'd1 << DATA_WIDTH) - 64'd1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RED  = 4'd1;
	localparam logic [3:0] S_CROD = 4'd2;
	localparam logic [3:0] S_CCON = 4'd3;
	localparam logic [3:0] S_BROD = 4'd4;
	localparam logic [3:0] S_BCON = 4'd5;
	localparam logic [3:0] S_DROD = 4'd6;
	localparam logic [3:0] S_DCON = 4'd7;
	localparam logic [3:0] S_MROD = 4'd8;
	localparam logic [3:0] S_MCON = 4'd9;
	localparam logic [3:0] S_RROD = 4'd10;
	localparam logic [3:0] S_RCON = 4'd11;
	localparam logic [3:0] S_BARN = 4'd12;
	localparam logic [3:0] S_MONO = 4'd13;
	localparam logic [3:0] S_OUT  = 4'd14;

	logic [63:0] prime_q, base_cfg_q, rod_q, cone_q, sig_q;
	logic [31:0] alpha_q, beta_q;
	logic [33:0] seal_mf_q, seal_ring_q, seal_barn_q;
	logic [63:0] seal_mono_q;

	logic [3:0]  state_q;
	logic        busy_q;
	logic [63:0] b_q, crod_q, brod_q, bcon_q, drod_q, mrod_q, mcon_q;
	logic [63:0] rrod_q;
	logic [63:0] small_m;
	logic [63:0] lock_sum;

	mcl_pkg::pow_req_t preq;
	mcl_pkg::pow_rsp_t prsp;

	mcl_powmod u_pow (.clk(clk), .arst_n(arst_n), .req(preq), .rsp(prsp));

	assign small_m  = {32'd0, alpha_q} + {32'd0, beta_q};
	assign lock_sum = ((base_cfg_q & DW_MASK) + (req.npn_value & DW_MASK) -
		(req.pnp_value & DW_MASK)) & DW_MASK;
	assign req.ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q    <= mcl_pkg::RST_PRIME;
			base_cfg_q <= mcl_pkg::RST_BASE;
			rod_q      <= mcl_pkg::RST_ROD;
			cone_q     <= mcl_pkg::RST_CONE;
			sig_q      <= mcl_pkg::RST_SIGNAL;
			alpha_q    <= mcl_pkg::RST_ALPHA;
			beta_q     <= mcl_pkg::RST_BETA;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcl_pkg::REG_PRIME:  prime_q    <= cfg_data;
				mcl_pkg::REG_BASE:   base_cfg_q <= cfg_data;
				mcl_pkg::REG_ROD:    rod_q      <= cfg_data;
				mcl_pkg::REG_CONE:   cone_q     <= cfg_data;
				mcl_pkg::REG_SIGNAL: sig_q      <= cfg_data;
				mcl_pkg::REG_ALPHA:  alpha_q    <= cfg_data[31:0];
				mcl_pkg::REG_BETA:   beta_q     <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= 1'b0;
			res.valid   <= 1'b0;
			preq.start  <= 1'b0;
			seal_mf_q   <= '0;
			seal_ring_q <= '0;
			seal_barn_q <= '0;
			seal_mono_q <= '0;
		end else begin
			preq.start <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && !busy_q) begin
						busy_q <= 1'b1;
						if (req.lock_enable && prime_q != 64'd0) begin
							preq <= '{1'b1, lock_sum, 64'd1, prime_q};
							state_q <= S_RED;
						end else begin
							b_q  <= req.lock_enable ? lock_sum : (base_cfg_q & DW_MASK);
							preq <= '{1'b1, req.lock_enable ? lock_sum :
								(base_cfg_q & DW_MASK), rod_q, prime_q};
							state_q <= S_CROD;
						end
					end
				end
				S_RED: if (prsp.done) begin
					b_q     <= prsp.value;
					preq    <= '{1'b1, prsp.value, rod_q, prime_q};
					state_q <= S_CROD;
				end
				S_CROD: if (prsp.done) begin
					crod_q  <= prsp.value;
					preq    <= '{1'b1, b_q, cone_q, prime_q};
					state_q <= S_CCON;
				end
				S_CCON: if (prsp.done) begin
					preq    <= '{1'b1, prsp.value, rod_q, prime_q};
					state_q <= S_BROD;
				end
				S_BROD: if (prsp.done) begin
					brod_q  <= prsp.value;
					preq    <= '{1'b1, crod_q, cone_q, prime_q};
					state_q <= S_BCON;
				end
				S_BCON: if (prsp.done) begin
					bcon_q  <= prsp.value;
					preq    <= '{1'b1, brod_q, sig_q, small_m};
					state_q <= S_DROD;
				end
				S_DROD: if (prsp.done) begin
					drod_q  <= prsp.value;
					preq    <= '{1'b1, bcon_q, sig_q, small_m};
					state_q <= S_DCON;
				end
				S_DCON: if (prsp.done) begin
					preq    <= '{1'b1, prsp.value, sig_q, small_m};
					state_q <= S_MROD;
				end
				S_MROD: if (prsp.done) begin
					mrod_q  <= prsp.value;
					preq    <= '{1'b1, drod_q, sig_q, small_m};
					state_q <= S_MCON;
				end
				S_MCON: if (prsp.done) begin
					mcon_q <= prsp.value;
					if (prsp.value != mrod_q) begin
						res.converged  <= 1'b0;
						res.fail_stage <= mcl_pkg::FAIL_MANIFOLD;
						state_q        <= S_OUT;
					end else begin
						preq    <= '{1'b1, brod_q, mrod_q, small_m};
						state_q <= S_RROD;
					end
				end
				S_RROD: if (prsp.done) begin
					rrod_q  <= prsp.value;
					preq    <= '{1'b1, bcon_q, mcon_q, small_m};
					state_q <= S_RCON;
				end
				S_RCON: if (prsp.done) begin
					if (prsp.value != rrod_q) begin
						res.converged  <= 1'b0;
						res.fail_stage <= mcl_pkg::FAIL_RING;
						state_q        <= S_OUT;
					end else begin
						preq    <= '{1'b1, rrod_q, mrod_q, small_m};
						state_q <= S_BARN;
					end
				end
				S_BARN: if (prsp.done) begin
					seal_mf_q   <= mrod_q[33:0];
					seal_ring_q <= rrod_q[33:0];
					seal_barn_q <= prsp.value[33:0];
					preq        <= '{1'b1, small_m, small_m, prime_q};
					state_q     <= S_MONO;
				end
				S_MONO: if (prsp.done) begin
					seal_mono_q    <= prsp.value;
					res.converged  <= 1'b1;
					res.fail_stage <= mcl_pkg::FAIL_NONE;
					state_q        <= S_OUT;
				end
				S_OUT: begin
					if (!res.valid) begin
						res.valid <= 1'b1;
					end else if (res.ready) begin
						res.valid <= 1'b0;
						busy_q    <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.manifold_out = seal_mf_q[32:0];
	assign res.ring_out     = seal_ring_q[32:0];
	assign res.barn_out     = seal_barn_q[32:0];
	assign res.monopole_out = seal_mono_q;

endmodule

[rtl/mcl_checker.sv]
// ----------------------------------------------------------------------------
// mcl_checker: port-level checks of the modexp cascade lock check unit
// Watches the request and result handshakes over time.
// ----------------------------------------------------------------------------
module mcl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        converged,
	input logic [1:0]  fail_stage
);

	// accepting an item closes the request side
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("ready after accept");

	// no request taken while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready) else $error("ready with pending result");

	a_conv: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (converged == (fail_stage == mcl_pkg::FAIL_NONE)))
		else $error("converged and fail_stage disagree");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid) else $error("result dropped");

endmodule

bind modexp_cascade_lock_check_unit mcl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.res_valid(res.valid), .res_ready(res.ready), .converged(res.converged),
	.fail_stage(res.fail_stage)
);
